// ----- rtl/core/shab_pkg.sv -----
// ============================================================================
// shab_pkg - shared types, constants and functions of the SHA-256 hasher
// Round constants, initial hash values, sigma functions and control structs.
// ============================================================================
package shab_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_POS     = 56;
    localparam int ROUNDS      = 64;

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef logic [31:0]      t_word;
    typedef logic [7:0][31:0] t_chain;

    localparam t_word K_ROUND [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Element 0 is word a (the first digest word).
    localparam t_chain H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    typedef struct packed {
        logic shift_byte;   // push one message byte into the block window
        logic shift_word;   // advance the schedule by one word
    } t_sched_ctrl;

    typedef struct packed {
        logic start;        // copy chaining words into the working words
        logic round;        // run one compression round
        logic fold;         // add working words into chaining words
        logic restart;      // return chaining words to the initial values
    } t_core_ctrl;

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ----- rtl/core/shab_msg_sched.sv -----
// ============================================================================
// shab_msg_sched - block window and message schedule
// Gathers message bytes into a 512-bit window and expands it word by word.
// ============================================================================
module shab_msg_sched (
    input  logic                  i_clk,
    input  shab_pkg::t_sched_ctrl i_ctrl,
    input  logic [7:0]            i_byte,
    output shab_pkg::t_word       o_w
);

    logic [511:0]    r_blk;
    logic [511:0]    n_blk;
    shab_pkg::t_word w_new;

    // Word 0 (oldest) sits in the top 32 bits.
    assign o_w   = r_blk[511:480];
    assign w_new = r_blk[511:480] + shab_pkg::small_sigma0(r_blk[479:448])
                 + r_blk[223:192] + shab_pkg::small_sigma1(r_blk[63:32]);

    always_comb begin
        n_blk = r_blk;
        if (i_ctrl.shift_byte) begin
            n_blk = {r_blk[503:0], i_byte};
        end else if (i_ctrl.shift_word) begin
            n_blk = {r_blk[479:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
    end

endmodule

// ----- rtl/core/shab_round_core.sv -----
// ============================================================================
// shab_round_core - shared compression round unit
// Holds the chaining and working words and runs one round per cycle.
// ============================================================================
module shab_round_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  shab_pkg::t_core_ctrl i_ctrl,
    input  shab_pkg::t_word      i_k,
    input  shab_pkg::t_word      i_w,
    output shab_pkg::t_chain     o_chain
);

    shab_pkg::t_chain r_chain;
    shab_pkg::t_chain n_chain;
    shab_pkg::t_chain r_work;
    shab_pkg::t_chain n_work;
    shab_pkg::t_word  t1;
    shab_pkg::t_word  t2;
    shab_pkg::t_word  ch;
    shab_pkg::t_word  maj;

    assign o_chain = r_chain;

    assign ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
               ^ (r_work[1] & r_work[2]);
    assign t1  = r_work[7] + shab_pkg::big_sigma1(r_work[4]) + ch + i_k + i_w;
    assign t2  = shab_pkg::big_sigma0(r_work[0]) + maj;

    always_comb begin
        n_work = r_work;
        if (i_ctrl.start) begin
            n_work = r_chain;
        end else if (i_ctrl.round) begin
            n_work[7] = r_work[6];
            n_work[6] = r_work[5];
            n_work[5] = r_work[4];
            n_work[4] = r_work[3] + t1;
            n_work[3] = r_work[2];
            n_work[2] = r_work[1];
            n_work[1] = r_work[0];
            n_work[0] = t1 + t2;
        end
    end

    always_comb begin
        n_chain = r_chain;
        if (i_ctrl.restart) begin
            n_chain = shab_pkg::H_INIT;
        end else if (i_ctrl.fold) begin
            for (int i = 0; i < 8; i++) begin
                n_chain[i] = r_chain[i] + r_work[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= shab_pkg::H_INIT;
        end else begin
            r_chain <= n_chain;
        end
    end

endmodule

// ----- rtl/core/sha256_byte_stream_hasher.sv -----
// ============================================================================
// sha256_byte_stream_hasher - SHA-256 over a byte stream
// Absorbs one byte per request, pads on finish and returns the digest.
// ============================================================================
// A data byte (action 0) is absorbed when the request is taken; when it
// completes a 64-byte block the block is compressed by a single round unit,
// one round per cycle, and the result is then folded into the chaining words.
// A finish request (action 1) pushes the 0x80 mark, zero bytes and the 64-bit
// big-endian bit length one byte per cycle through the same block window,
// compressing one or two final blocks, then returns four 64-bit digest words,
// index 0 first, with last word flagged on index 3. The input is not ready
// while a block is being compressed, padded or while the digest is being
// returned. After the last digest word is taken the hasher is ready for a
// new message.
// ============================================================================
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;  // take data bytes or a finish request
    localparam logic [2:0] ST_PAD  = 3'd1;  // push padding and length bytes
    localparam logic [2:0] ST_COMP = 3'd2;  // 64 compression rounds
    localparam logic [2:0] ST_FOLD = 3'd3;  // add working words into the chain
    localparam logic [2:0] ST_OUT  = 3'd4;  // return the digest words

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_fill, n_fill;        // bytes in the current block
    logic [63:0] r_msg, n_msg;          // message length in bytes
    logic [63:0] r_len, n_len;          // bit length, shifted out MSB first
    logic        r_mark, n_mark;        // next pad byte is the 0x80 mark
    logic        r_last_blk, n_last_blk;// this block carries the length
    logic        r_in_pad, n_in_pad;    // a finish request is in progress
    logic [5:0]  r_round, n_round;
    logic [1:0]  r_widx, n_widx;

    logic                 in_fire;
    logic                 out_fire;
    logic                 len_slot;
    logic [7:0]           pad_byte;
    logic [7:0]           sched_byte;
    logic [2:0]           word_sel;
    shab_pkg::t_sched_ctrl sched_ctrl;
    shab_pkg::t_core_ctrl  core_ctrl;
    shab_pkg::t_word       w_t;
    shab_pkg::t_chain      chain;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign in_fire     = i_in_valid & o_in_ready;
    assign out_fire    = o_out_valid & i_out_ready;

    // Length bytes fill the last eight slots of the final block only.
    assign len_slot   = r_last_blk && !r_mark
                     && (r_fill >= 6'(shab_pkg::LEN_POS));
    assign pad_byte   = r_mark   ? shab_pkg::PAD_MARK :
                        len_slot ? r_len[63:56] : 8'h00;
    assign sched_byte = (r_state == ST_IDLE) ? i_data_byte : pad_byte;

    // Digest word pair select: chain words 2k and 2k+1.
    assign word_sel      = {r_widx, 1'b0};
    assign o_digest_word = {chain[word_sel], chain[word_sel + 3'd1]};
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == 2'd3);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_msg      = r_msg;
        n_len      = r_len;
        n_mark     = r_mark;
        n_last_blk = r_last_blk;
        n_in_pad   = r_in_pad;
        n_round    = r_round;
        n_widx     = r_widx;
        sched_ctrl = '0;
        core_ctrl  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (!i_action) begin
                        // Absorb the byte; a full block starts compression.
                        sched_ctrl.shift_byte = 1'b1;
                        n_fill = r_fill + 6'd1;
                        n_msg  = r_msg + 64'd1;
                        if (r_fill == 6'(shab_pkg::BLOCK_BYTES - 1)) begin
                            core_ctrl.start = 1'b1;
                            n_round = '0;
                            n_state = ST_COMP;
                        end
                    end else begin
                        // Latch the bit length and begin padding.
                        n_len      = {r_msg[60:0], 3'b000};
                        n_mark     = 1'b1;
                        n_last_blk = (r_fill < 6'(shab_pkg::LEN_POS));
                        n_in_pad   = 1'b1;
                        n_state    = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                sched_ctrl.shift_byte = 1'b1;
                n_mark = 1'b0;
                if (len_slot) begin
                    n_len = {r_len[55:0], 8'h00};
                end
                n_fill = r_fill + 6'd1;
                if (r_fill == 6'(shab_pkg::BLOCK_BYTES - 1)) begin
                    core_ctrl.start = 1'b1;
                    n_round = '0;
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                sched_ctrl.shift_word = 1'b1;
                core_ctrl.round = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == 6'(shab_pkg::ROUNDS - 1)) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                core_ctrl.fold = 1'b1;
                if (!r_in_pad) begin
                    n_state = ST_IDLE;
                end else if (r_last_blk) begin
                    n_widx  = '0;
                    n_state = ST_OUT;
                end else begin
                    // Mark spilled past the length slots: one more block.
                    n_last_blk = 1'b1;
                    n_state    = ST_PAD;
                end
            end
            ST_OUT: begin
                if (out_fire) begin
                    n_widx = r_widx + 2'd1;
                    if (r_widx == 2'd3) begin
                        // Drop the message state for the next message.
                        core_ctrl.restart = 1'b1;
                        n_msg    = '0;
                        n_in_pad = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_msg      <= '0;
            r_mark     <= 1'b0;
            r_last_blk <= 1'b0;
            r_in_pad   <= 1'b0;
            r_round    <= '0;
            r_widx     <= '0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_msg      <= n_msg;
            r_mark     <= n_mark;
            r_last_blk <= n_last_blk;
            r_in_pad   <= n_in_pad;
            r_round    <= n_round;
            r_widx     <= n_widx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    shab_msg_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (sched_ctrl),
        .i_byte (sched_byte),
        .o_w    (w_t)
    );

    shab_round_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (core_ctrl),
        .i_k     (shab_pkg::K_ROUND[r_round]),
        .i_w     (w_t),
        .o_chain (chain)
    );

endmodule
